FILE: hdl/lrubc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrubc_pkg
// Shared types and codes of the block buffer cache directory: opcodes,
// disk request and status codes, the lookup token and the commit command.
// ----------------------------------------------------------------------------
package lrubc_pkg;

  // Default sizes of the directory.
  localparam int SLOTS_DEFAULT      = 16;
  localparam int COUNT_BITS_DEFAULT = 8;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_DONE    = 2'd3
  } opcode_t;

  // Disk request codes.
  localparam logic [1:0] DR_NONE  = 2'd0;
  localparam logic [1:0] DR_READ  = 2'd1;
  localparam logic [1:0] DR_WRITE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBUF = 2'd1;
  localparam logic [1:0] ST_UNREF = 2'd2;

  // Update applied to the cells once a lookup has finished.
  typedef enum logic [2:0] {
    CM_NONE  = 3'd0,
    CM_HIT   = 3'd1,
    CM_ALLOC = 3'd2,
    CM_WRITE = 3'd3,
    CM_DEC   = 3'd4,
    CM_MTF   = 3'd5,
    CM_DONE  = 3'd6
  } commit_kind_t;

  // Fixed-width part of the lookup token that walks the chain.
  typedef struct packed {
    logic        active;
    opcode_t     opcode;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [3:0]  slot_in;
    logic        m_found;
    logic [7:0]  m_device;
    logic [31:0] m_block;
    logic        m_valid;
    logic        m_dirty;
    logic        f_found;
  } token_t;

  // Fixed-width part of one directory entry.
  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] block_number;
    logic        valid;
    logic        dirty;
  } entry_t;

  // Fixed-width part of the commit command broadcast to every cell.
  typedef struct packed {
    commit_kind_t kind;
    logic [7:0]   device;
    logic [31:0]  block_number;
  } commit_t;

endpackage
`default_nettype wire

FILE: hdl/lrubc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrubc_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface lrubc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [3:0]  slot_in;

  modport source (output valid, opcode, device, block_number, slot_in, input ready);
  modport sink   (input valid, opcode, device, block_number, slot_in, output ready);
endinterface
`default_nettype wire

FILE: hdl/lrubc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrubc_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface lrubc_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] slot_out;
  logic       hit;
  logic [1:0] disk_request;
  logic [1:0] status;

  modport source (output valid, slot_out, hit, disk_request, status, input ready);
  modport sink   (input valid, slot_out, hit, disk_request, status, output ready);
endinterface
`default_nettype wire

FILE: hdl/lrubc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrubc_cell
// One recency position of the directory. It holds the entry at that position,
// examines the lookup token as it passes and hands it on in the next cycle, and
// applies the commit command that ends each lookup.
// ----------------------------------------------------------------------------
module lrubc_cell import lrubc_pkg::*; #(
  parameter int SLOT_BITS  = 4,
  parameter int COUNT_BITS = 8,
  parameter int POS        = 0,
  parameter int RESET_SLOT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  // Token from the previous position.
  input  token_t                tok_in,
  input  logic [SLOT_BITS-1:0]  tin_m_pos,
  input  logic [SLOT_BITS-1:0]  tin_m_slot,
  input  logic [COUNT_BITS-1:0] tin_m_count,
  input  logic [SLOT_BITS-1:0]  tin_f_pos,
  input  logic [SLOT_BITS-1:0]  tin_f_slot,
  // Token to the next position.
  output token_t                tok_out,
  output logic [SLOT_BITS-1:0]  tout_m_pos,
  output logic [SLOT_BITS-1:0]  tout_m_slot,
  output logic [COUNT_BITS-1:0] tout_m_count,
  output logic [SLOT_BITS-1:0]  tout_f_pos,
  output logic [SLOT_BITS-1:0]  tout_f_slot,
  // Commit command.
  input  commit_t               cmt,
  input  logic [SLOT_BITS-1:0]  cmt_pos,
  // Entry of the previous position, used when the order shifts.
  input  entry_t                prev_ent,
  input  logic [SLOT_BITS-1:0]  prev_slot,
  input  logic [COUNT_BITS-1:0] prev_count,
  // Entry held here.
  output entry_t                ent,
  output logic [SLOT_BITS-1:0]  slot_id,
  output logic [COUNT_BITS-1:0] count
);

  localparam int CMP_BITS = (SLOT_BITS > 4) ? SLOT_BITS : 4;
  localparam logic [SLOT_BITS-1:0] MY_POS = SLOT_BITS'(POS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  token_t                tok_next;
  logic [SLOT_BITS-1:0]  m_pos_next;
  logic [SLOT_BITS-1:0]  m_slot_next;
  logic [COUNT_BITS-1:0] m_count_next;
  logic [SLOT_BITS-1:0]  f_pos_next;
  logic [SLOT_BITS-1:0]  f_slot_next;
  logic                  is_read;
  logic                  tag_match;
  logic                  slot_match;

  // Examine the token: first match from the most recent end, and the last
  // unreferenced clean entry seen on a read, which is the least recent one.
  always_comb begin
    tok_next     = tok_in;
    m_pos_next   = tin_m_pos;
    m_slot_next  = tin_m_slot;
    m_count_next = tin_m_count;
    f_pos_next   = tin_f_pos;
    f_slot_next  = tin_f_slot;
    is_read      = (tok_in.opcode == OP_READ);
    tag_match    = (ent.device == tok_in.device) &&
                   (ent.block_number == tok_in.block_number);
    slot_match   = (CMP_BITS'(slot_id) == CMP_BITS'(tok_in.slot_in));
    if (tok_in.active && !tok_in.m_found && (is_read ? tag_match : slot_match)) begin
      tok_next.m_found  = 1'b1;
      tok_next.m_device = ent.device;
      tok_next.m_block  = ent.block_number;
      tok_next.m_valid  = ent.valid;
      tok_next.m_dirty  = ent.dirty;
      m_pos_next        = MY_POS;
      m_slot_next       = slot_id;
      m_count_next      = count;
    end
    if (tok_in.active && is_read && (count == '0) && !ent.dirty) begin
      tok_next.f_found = 1'b1;
      f_pos_next       = MY_POS;
      f_slot_next      = slot_id;
    end
  end

  // Hand the token on.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    tout_m_pos   <= m_pos_next;
    tout_m_slot  <= m_slot_next;
    tout_m_count <= m_count_next;
    tout_f_pos   <= f_pos_next;
    tout_f_slot  <= f_slot_next;
  end

  // Entry state and its updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent     <= '0;
      slot_id <= SLOT_BITS'(RESET_SLOT);
      count   <= '0;
    end else begin
      case (cmt.kind)
        CM_HIT: begin
          if ((cmt_pos == MY_POS) && (count != COUNT_MAX)) begin
            count <= count + COUNT_BITS'(1);
          end
        end
        CM_ALLOC: begin
          if (cmt_pos == MY_POS) begin
            ent.device       <= cmt.device;
            ent.block_number <= cmt.block_number;
            ent.valid        <= 1'b0;
            ent.dirty        <= 1'b0;
            count            <= COUNT_BITS'(1);
          end
        end
        CM_WRITE: begin
          if (cmt_pos == MY_POS) begin
            ent.dirty <= 1'b1;
          end
        end
        CM_DEC: begin
          if (cmt_pos == MY_POS) begin
            count <= count - COUNT_BITS'(1);
          end
        end
        CM_MTF: begin
          // Positions up to the released one shift back by one.
          if (MY_POS <= cmt_pos) begin
            ent     <= prev_ent;
            slot_id <= prev_slot;
            count   <= prev_count;
          end
        end
        CM_DONE: begin
          if (cmt_pos == MY_POS) begin
            ent.valid <= 1'b1;
            ent.dirty <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lru_block_buffer_cache_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_core
// Directory of a disk block buffer cache kept in recency order, with
// reference counts, valid and dirty marks.
// ----------------------------------------------------------------------------
// The directory is a chain of SLOTS cells, one per recency position, most
// recent first. Each request item is registered and then walks the chain as
// a token, one cell per cycle, collecting the first tag or slot match and the
// least recent free clean slot. When it leaves the last cell the result is
// formed and one commit command updates the cells, including the shift that
// moves a released slot to the front. One item is in progress at a time: the
// next one is taken in the cycle after the previous one has committed, so the
// block cannot take a new item before it is through with the last one.
// A finished result waits in the output register until it is taken, and a
// lookup that finishes while that register is still full waits with it.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_core import lrubc_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  lrubc_req_if.sink     req,
  lrubc_rsp_if.source   rsp
);

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int CMP_BITS  = (SLOT_BITS > 4) ? SLOT_BITS : 4;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Token chain.
  token_t                tok     [SLOTS+1];
  logic [SLOT_BITS-1:0]  t_m_pos [SLOTS+1];
  logic [SLOT_BITS-1:0]  t_m_slot[SLOTS+1];
  logic [COUNT_BITS-1:0] t_m_count[SLOTS+1];
  logic [SLOT_BITS-1:0]  t_f_pos [SLOTS+1];
  logic [SLOT_BITS-1:0]  t_f_slot[SLOTS+1];

  // Entries and their neighbor inputs.
  entry_t                ent       [SLOTS];
  logic [SLOT_BITS-1:0]  slot_id   [SLOTS];
  logic [COUNT_BITS-1:0] count     [SLOTS];
  entry_t                prev_ent  [SLOTS];
  logic [SLOT_BITS-1:0]  prev_slot [SLOTS];
  logic [COUNT_BITS-1:0] prev_count[SLOTS];

  token_t                head_tok;
  token_t                fin_tok;
  logic [SLOT_BITS-1:0]  fin_m_pos;
  logic [SLOT_BITS-1:0]  fin_m_slot;
  logic [COUNT_BITS-1:0] fin_m_count;
  logic [SLOT_BITS-1:0]  fin_f_pos;
  logic [SLOT_BITS-1:0]  fin_f_slot;

  commit_t               cmt;
  logic [SLOT_BITS-1:0]  cmt_pos;
  entry_t                mtf_ent;
  logic                  accept;
  logic                  fire;
  logic [CMP_BITS-1:0]   m_slot_ext;
  logic [CMP_BITS-1:0]   f_slot_ext;
  logic [3:0]            r_slot;
  logic                  r_hit;
  logic [1:0]            r_req;
  logic [1:0]            r_status;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fire      = (state == S_FINISH) && (!rsp.valid || rsp.ready);

  // Head of the chain: a fresh token for each accepted item.
  always_ff @(posedge clk) begin
    head_tok.opcode       <= opcode_t'(req.opcode);
    head_tok.device       <= req.device;
    head_tok.block_number <= req.block_number;
    head_tok.slot_in      <= req.slot_in;
    head_tok.m_found      <= 1'b0;
    head_tok.m_device     <= '0;
    head_tok.m_block      <= '0;
    head_tok.m_valid      <= 1'b0;
    head_tok.m_dirty      <= 1'b0;
    head_tok.f_found      <= 1'b0;
    if (rst) begin
      head_tok.active <= 1'b0;
    end else begin
      head_tok.active <= accept;
    end
  end

  assign tok[0]       = head_tok;
  assign t_m_pos[0]   = '0;
  assign t_m_slot[0]  = '0;
  assign t_m_count[0] = '0;
  assign t_f_pos[0]   = '0;
  assign t_f_slot[0]  = '0;

  // The entry moved to the front enters the chain at position zero.
  assign mtf_ent.device       = fin_tok.m_device;
  assign mtf_ent.block_number = fin_tok.m_block;
  assign mtf_ent.valid        = fin_tok.m_valid;
  assign mtf_ent.dirty        = fin_tok.m_dirty;

  // The chain of cells.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_ent[i]   = mtf_ent;
      assign prev_slot[i]  = fin_m_slot;
      assign prev_count[i] = '0;
    end else begin : g_next
      assign prev_ent[i]   = ent[i-1];
      assign prev_slot[i]  = slot_id[i-1];
      assign prev_count[i] = count[i-1];
    end

    lrubc_cell #(
      .SLOT_BITS  (SLOT_BITS),
      .COUNT_BITS (COUNT_BITS),
      .POS        (i),
      .RESET_SLOT (SLOTS - 1 - i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (tok[i]),
      .tin_m_pos    (t_m_pos[i]),
      .tin_m_slot   (t_m_slot[i]),
      .tin_m_count  (t_m_count[i]),
      .tin_f_pos    (t_f_pos[i]),
      .tin_f_slot   (t_f_slot[i]),
      .tok_out      (tok[i+1]),
      .tout_m_pos   (t_m_pos[i+1]),
      .tout_m_slot  (t_m_slot[i+1]),
      .tout_m_count (t_m_count[i+1]),
      .tout_f_pos   (t_f_pos[i+1]),
      .tout_f_slot  (t_f_slot[i+1]),
      .cmt          (cmt),
      .cmt_pos      (cmt_pos),
      .prev_ent     (prev_ent[i]),
      .prev_slot    (prev_slot[i]),
      .prev_count   (prev_count[i]),
      .ent          (ent[i]),
      .slot_id      (slot_id[i]),
      .count        (count[i])
    );
  end

  // Capture the token as it leaves the last cell.
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && tok[SLOTS].active) begin
      fin_tok     <= tok[SLOTS];
      fin_m_pos   <= t_m_pos[SLOTS];
      fin_m_slot  <= t_m_slot[SLOTS];
      fin_m_count <= t_m_count[SLOTS];
      fin_f_pos   <= t_f_pos[SLOTS];
      fin_f_slot  <= t_f_slot[SLOTS];
    end
  end

  assign m_slot_ext = CMP_BITS'(fin_m_slot);
  assign f_slot_ext = CMP_BITS'(fin_f_slot);

  // Result and commit command of the finished lookup.
  always_comb begin
    cmt.kind         = CM_NONE;
    cmt.device       = fin_tok.device;
    cmt.block_number = fin_tok.block_number;
    cmt_pos          = fin_m_pos;
    r_slot           = fin_tok.slot_in;
    r_hit            = 1'b0;
    r_req            = DR_NONE;
    r_status         = ST_OK;
    case (fin_tok.opcode)
      OP_READ: begin
        if (fin_tok.m_found) begin
          r_slot   = m_slot_ext[3:0];
          r_hit    = 1'b1;
          r_req    = fin_tok.m_valid ? DR_NONE : DR_READ;
          cmt.kind = CM_HIT;
        end else if (fin_tok.f_found) begin
          r_slot   = f_slot_ext[3:0];
          r_req    = DR_READ;
          cmt.kind = CM_ALLOC;
          cmt_pos  = fin_f_pos;
        end else begin
          r_slot   = '0;
          r_status = ST_NOBUF;
        end
      end
      OP_WRITE: begin
        if (fin_tok.m_found) begin
          r_req    = DR_WRITE;
          cmt.kind = CM_WRITE;
        end
      end
      OP_RELEASE: begin
        if (fin_tok.m_found) begin
          if (fin_m_count == '0) begin
            r_status = ST_UNREF;
          end else if (fin_m_count == COUNT_BITS'(1)) begin
            cmt.kind = CM_MTF;
          end else begin
            cmt.kind = CM_DEC;
          end
        end
      end
      OP_DONE: begin
        if (fin_tok.m_found) begin
          cmt.kind = CM_DONE;
        end
      end
      default: begin
      end
    endcase
    if (!fire) begin
      cmt.kind = CM_NONE;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.slot_out     <= r_slot;
      rsp.hit          <= r_hit;
      rsp.disk_request <= r_req;
      rsp.status       <= r_status;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok[SLOTS].active) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
